// ===== rtl/quiet_run_remover_defines.svh =====
// assertion macros shared by the quiet run remover rtl
`ifndef QUIET_RUN_REMOVER_DEFINES_SVH
`define QUIET_RUN_REMOVER_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off while rst_ni is low
`define QRR_ASSERT_IMP(label, lhs, rhs) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (lhs) |-> (rhs)) \
    else $error("quiet_run_remover: implication check failed");

// next-cycle implication, clocked on clk_i, off while rst_ni is low
`define QRR_ASSERT_NXT(label, lhs, rhs) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (lhs) |=> (rhs)) \
    else $error("quiet_run_remover: next-cycle check failed");

`endif

// ===== rtl/qrr_pkg.sv =====
// shared types and constants of the quiet run remover
package qrr_pkg;

  localparam int unsigned MIN_RUN_DEF  = 32;
  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned NOISE_W      = 15;
  localparam int unsigned APB_DATA_W   = 32;
  localparam int unsigned APB_ADDR_W   = 3;
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);

  // register index, taken from paddr bit 2
  localparam logic REG_NOISE_LEVEL = 1'b0;

  // classified item handed from the front to the back
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clip_end;
    logic                       quiet;
  } item_t;

  // one result item
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       run_last;
    logic                       clip_done;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic flushing;
    logic run_short;
  } back_status_t;

  typedef enum logic {
    ST_IDLE,
    ST_FLUSH
  } back_state_e;

endpackage

// ===== rtl/qrr_front.sv =====
// front end: noise level register and quiet classification of incoming items
module qrr_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // item in
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [qrr_pkg::SAMPLE_W-1:0] in_sample_i,
  input  logic                               in_clip_end_i,
  // classified item out
  output logic                               cls_valid_o,
  input  logic                               cls_ready_i,
  output qrr_pkg::item_t                     cls_item_o,
  // register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [qrr_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [qrr_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [qrr_pkg::APB_DATA_W-1:0]     prdata
);

  logic [qrr_pkg::NOISE_W-1:0]    noise_q;
  logic [qrr_pkg::NOISE_W-1:0]    noise_d;
  logic [qrr_pkg::SAMPLE_W:0]     mag;
  logic                           noise_wr;

  assign noise_wr = psel && penable && pwrite && (paddr[2] == qrr_pkg::REG_NOISE_LEVEL);
  assign noise_d  = noise_wr ? pwdata[qrr_pkg::NOISE_W-1:0] : noise_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_q <= '0;
    end else begin
      noise_q <= noise_d;
    end
  end

  always_comb begin
    if (paddr[2] == qrr_pkg::REG_NOISE_LEVEL) begin
      prdata = {{(qrr_pkg::APB_DATA_W - qrr_pkg::NOISE_W){1'b0}}, noise_q};
    end else begin
      prdata = '0;
    end
  end

  // magnitude one bit wider so that the most negative sample gives 2^15
  always_comb begin
    if (in_sample_i[qrr_pkg::SAMPLE_W-1]) begin
      mag = {1'b1, {qrr_pkg::SAMPLE_W{1'b0}}} - {1'b0, in_sample_i};
    end else begin
      mag = {1'b0, in_sample_i};
    end
  end

  assign cls_valid_o         = in_valid_i;
  assign in_ready_o          = cls_ready_i;
  assign cls_item_o.sample   = in_sample_i;
  assign cls_item_o.clip_end = in_clip_end_i;
  assign cls_item_o.quiet    = mag <= {2'b00, noise_q};

endmodule

// ===== rtl/qrr_queue.sv =====
// short queue of classified items between front and back
module qrr_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  output logic                  push_ready_o,
  input  qrr_pkg::item_t        push_item_i,
  output logic                  pop_valid_o,
  input  logic                  pop_i,
  output qrr_pkg::item_t        pop_item_o,
  output qrr_pkg::queue_status_t status_o
);

  qrr_pkg::item_t              slot_q [qrr_pkg::QUEUE_DEPTH];
  logic [qrr_pkg::QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [qrr_pkg::QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [qrr_pkg::QPTR_W:0]    fill_q, fill_d;
  logic                        push;
  logic                        pop;

  assign push_ready_o = fill_q != (qrr_pkg::QPTR_W+1)'(qrr_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = fill_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_item_o   = slot_q[rd_ptr_q];

  assign status_o.full  = !push_ready_o;
  assign status_o.empty = !pop_valid_o;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + 1'b1;
    end else if (pop && !push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== rtl/qrr_back.sv =====
// back end: run counter, held sample store, flush sequencer and output register
module qrr_back #(
  parameter int unsigned MIN_RUN = qrr_pkg::MIN_RUN_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 head_valid_i,
  input  qrr_pkg::item_t       head_item_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output qrr_pkg::result_t     out_result_o,
  output qrr_pkg::back_status_t status_o
);

  localparam int unsigned CNT_W     = $clog2(MIN_RUN + 1);
  localparam int unsigned MEM_DEPTH = (MIN_RUN > 3) ? MIN_RUN - 2 : 1;
  localparam int unsigned AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  logic signed [qrr_pkg::SAMPLE_W-1:0] mem [MEM_DEPTH];
  logic signed [qrr_pkg::SAMPLE_W-1:0] rdata_q;

  qrr_pkg::back_state_e state_q, state_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     rd_idx_q, rd_idx_d;
  logic                 pend_q, pend_d;
  logic                 out_valid_q;
  qrr_pkg::result_t     out_q, out_d;
  logic                 out_load;
  logic                 wr_en;
  logic                 rd_en;
  logic                 load_ent;

  logic out_free, head_hold, short_run, need_flush, reads_left, flush_end;

  assign out_free   = !out_valid_q || out_ready_i;
  assign head_hold  = head_item_i.quiet && !head_item_i.clip_end;
  assign short_run  = count_q <= CNT_W'(MIN_RUN - 2);
  assign need_flush = !head_hold && short_run && (count_q != '0);
  assign reads_left = rd_idx_q != count_q;
  assign flush_end  = !reads_left && !pend_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      qrr_pkg::ST_IDLE: begin
        if (head_valid_i && need_flush) begin
          state_d = qrr_pkg::ST_FLUSH;
        end
      end
      qrr_pkg::ST_FLUSH: begin
        if (flush_end && out_free) begin
          state_d = qrr_pkg::ST_IDLE;
        end
      end
      default: state_d = qrr_pkg::ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    pop_o    = 1'b0;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    load_ent = 1'b0;
    out_load = 1'b0;
    out_d    = out_q;
    count_d  = count_q;
    rd_idx_d = rd_idx_q;
    pend_d   = pend_q;
    unique case (state_q)
      qrr_pkg::ST_IDLE: begin
        rd_idx_d = '0;
        pend_d   = 1'b0;
        if (head_valid_i) begin
          if (head_hold) begin
            pop_o = 1'b1;
            wr_en = count_q < CNT_W'(MIN_RUN - 2);
            if (count_q != CNT_W'(MIN_RUN)) begin
              count_d = count_q + 1'b1;
            end
          end else if (!need_flush && out_free) begin
            out_load        = 1'b1;
            out_d.sample    = head_item_i.sample;
            out_d.run_last  = 1'b1;
            out_d.clip_done = head_item_i.clip_end;
            pop_o           = 1'b1;
            count_d         = '0;
          end
        end
      end
      qrr_pkg::ST_FLUSH: begin
        load_ent = out_free && pend_q;
        rd_en    = reads_left && (!pend_q || load_ent);
        if (load_ent) begin
          out_load        = 1'b1;
          out_d.sample    = rdata_q;
          out_d.run_last  = 1'b0;
          out_d.clip_done = 1'b0;
        end
        if (rd_en) begin
          rd_idx_d = rd_idx_q + 1'b1;
        end
        pend_d = rd_en || (pend_q && !load_ent);
        if (flush_end && out_free) begin
          out_load        = 1'b1;
          out_d.sample    = head_item_i.sample;
          out_d.run_last  = 1'b1;
          out_d.clip_done = head_item_i.clip_end;
          pop_o           = 1'b1;
          count_d         = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= qrr_pkg::ST_IDLE;
      count_q     <= '0;
      rd_idx_q    <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rd_idx_q <= rd_idx_d;
      pend_q   <= pend_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  // held sample store
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[AW-1:0]] <= head_item_i.sample;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_idx_q[AW-1:0]];
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_result_o       = out_q;
  assign status_o.flushing  = state_q == qrr_pkg::ST_FLUSH;
  assign status_o.run_short = short_run;

endmodule

// ===== rtl/quiet_run_remover.sv =====
// top level of the quiet run remover: front, queue and back wired together
//
// usage
//  - s_axis carries one audio sample per item, tlast marks the final sample of a clip
//  - m_axis returns the surviving samples in order; tlast flags the last result
//    caused by one input item, tuser flags the final result of the clip
//  - the apb port holds noise_level at byte address 0; samples whose magnitude
//    is at most that level count as quiet; write it only while the block is idle
//  - quiet items not at clip end give no result, taken one per cycle outside a flush
//  - an item that ends a short run gives n held samples plus itself, n + 1
//    results paced by the single read port of the store, held samples first
//  - any other result is registered in the queue and then in the output register
//  - a two-item queue between front and back lets input continue while the
//    output register waits; when it fills, s_axis_tready drops
//  - a receiver stall freezes the output register and the flush sequencer;
//    nothing is lost or repeated
//  - reset clears the run count, queue, output valid and noise_level; the held
//    store needs no clearing since only entries of the current run are read
module quiet_run_remover #(
  parameter int unsigned MIN_RUN = qrr_pkg::MIN_RUN_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [qrr_pkg::SAMPLE_W-1:0]   s_axis_tdata,  // [15:0] sample
  input  logic                           s_axis_tlast,  // clip_end
  // output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [qrr_pkg::SAMPLE_W-1:0]   m_axis_tdata,  // [15:0] kept_sample
  output logic                           m_axis_tlast,  // run_last
  output logic                           m_axis_tuser,  // [0] clip_done
  // register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [qrr_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [qrr_pkg::APB_DATA_W-1:0] pwdata,
  output logic [qrr_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  `include "quiet_run_remover_defines.svh"

  logic                  cls_valid;
  logic                  cls_ready;
  qrr_pkg::item_t        cls_item;
  logic                  head_valid;
  qrr_pkg::item_t        head_item;
  logic                  pop;
  qrr_pkg::result_t      result;
  qrr_pkg::queue_status_t q_status;
  qrr_pkg::back_status_t  b_status;

  assign pready = 1'b1;

  // classification and register file
  qrr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_sample_i   (s_axis_tdata),
    .in_clip_end_i (s_axis_tlast),
    .cls_valid_o   (cls_valid),
    .cls_ready_i   (cls_ready),
    .cls_item_o    (cls_item),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata)
  );

  // decoupling queue
  qrr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (cls_valid),
    .push_ready_o (cls_ready),
    .push_item_i  (cls_item),
    .pop_valid_o  (head_valid),
    .pop_i        (pop),
    .pop_item_o   (head_item),
    .status_o     (q_status)
  );

  // run handling and result generation
  qrr_back #(
    .MIN_RUN (MIN_RUN)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_item_i  (head_item),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_result_o (result),
    .status_o     (b_status)
  );

  assign m_axis_tdata = result.sample;
  assign m_axis_tlast = result.run_last;
  assign m_axis_tuser = result.clip_done;

  // a full queue must hold off the input
  `QRR_ASSERT_IMP(a_full_blocks_input, q_status.full, !s_axis_tready)
  // the item being flushed stays at the queue head until its own result goes out
  `QRR_ASSERT_IMP(a_flush_has_head, b_status.flushing, !q_status.empty && b_status.run_short)
  // an item pushed into an empty queue is there in the next cycle
  `QRR_ASSERT_NXT(a_push_lands, s_axis_tvalid && s_axis_tready && q_status.empty,
                  !q_status.empty)
  // clip end result always closes the results of its item
  `QRR_ASSERT_IMP(a_done_is_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast)

endmodule

// ===== tb/tb_top.sv =====
// testbench of the quiet run remover: directed and random sample streams against a predictor
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned MIN_RUN      = qrr_pkg::MIN_RUN_DEF;
  localparam int unsigned HALF_PERIOD  = 4;
  // longest flush is MIN_RUN-1 results, plus pipeline and queue slack
  localparam int unsigned DRAIN_CYCLES = MIN_RUN + 16;
  localparam int unsigned TIMEOUT_NS   = 10_000_000;

  // byte addresses of the register port
  localparam logic [qrr_pkg::APB_ADDR_W-1:0] NOISE_LEVEL_ADDR =
    {qrr_pkg::REG_NOISE_LEVEL, 2'b00};
  localparam logic [qrr_pkg::APB_ADDR_W-1:0] SPARE_REG_ADDR   =
    {~qrr_pkg::REG_NOISE_LEVEL, 2'b00};

  logic                           clk_i;
  logic                           rst_ni;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [qrr_pkg::SAMPLE_W-1:0]   s_axis_tdata;   // [15:0] sample
  logic                           s_axis_tlast;   // clip_end
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [qrr_pkg::SAMPLE_W-1:0]   m_axis_tdata;   // [15:0] kept_sample
  logic                           m_axis_tlast;   // run_last
  logic                           m_axis_tuser;   // [0] clip_done
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [qrr_pkg::APB_ADDR_W-1:0] paddr;
  logic [qrr_pkg::APB_DATA_W-1:0] pwdata;
  logic [qrr_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  quiet_run_remover #(
    .MIN_RUN(MIN_RUN)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // predictor state: held quiet samples, run length, noise level
  logic [qrr_pkg::SAMPLE_W-1:0] held_copy [MIN_RUN];
  logic [5:0]                   quiet_run_len = '0;
  logic [qrr_pkg::NOISE_W-1:0]  quiet_limit   = '0;

  qrr_pkg::result_t kept_fifo [$];
  int unsigned      mismatch_count = 0;
  bit               idling_on      = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #(HALF_PERIOD) clk_i = ~clk_i;
  end

  // work out the kept samples caused by one accepted item
  task automatic predict_kept(input logic [qrr_pkg::SAMPLE_W-1:0] s, input logic clip_end);
    logic [qrr_pkg::SAMPLE_W:0] mag;
    int unsigned                n;
    qrr_pkg::result_t           r;
    mag = s[qrr_pkg::SAMPLE_W-1] ? (17'h10000 - {1'b0, s}) : {1'b0, s};
    if (mag <= {2'b00, quiet_limit} && !clip_end) begin
      // quiet, held back: only the first MIN_RUN-2 are stored
      if (quiet_run_len < MIN_RUN - 2) held_copy[quiet_run_len] = s;
      if (quiet_run_len < MIN_RUN) quiet_run_len++;
      return;
    end
    if (int'(quiet_run_len) + 1 < MIN_RUN) begin
      // short run goes out whole before this sample
      n = (quiet_run_len > MIN_RUN - 2) ? MIN_RUN - 2 : quiet_run_len;
      for (int unsigned i = 0; i < n; i++) begin
        r.sample    = held_copy[i];
        r.run_last  = 1'b0;
        r.clip_done = 1'b0;
        kept_fifo   = {kept_fifo, r};
      end
    end
    r.sample    = s;
    r.run_last  = 1'b1;
    r.clip_done = clip_end;
    kept_fifo   = {kept_fifo, r};
    quiet_run_len = '0;
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_sample(input logic [qrr_pkg::SAMPLE_W-1:0] s, input logic clip_end);
    int unsigned gap;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = s;
    s_axis_tlast  = clip_end;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_kept(s, clip_end);
    @(negedge clk_i);
  endtask

  task automatic write_register(input logic [qrr_pkg::APB_ADDR_W-1:0] addr,
                                input logic [qrr_pkg::APB_DATA_W-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    // any index past noise_level is ignored
    if (addr[2] == qrr_pkg::REG_NOISE_LEVEL) quiet_limit = value[qrr_pkg::NOISE_W-1:0];
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // input stops, every kept sample arrives, then quiet items still in flight settle
  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    while (kept_fifo.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_noise_level(input logic [qrr_pkg::APB_DATA_W-1:0] value);
    wait_idle();
    write_register(NOISE_LEVEL_ADDR, value);
  endtask

  function automatic logic [qrr_pkg::SAMPLE_W-1:0] quiet_value();
    logic [qrr_pkg::SAMPLE_W-1:0] m;
    m = 16'($urandom_range(0, quiet_limit));
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  function automatic logic [qrr_pkg::SAMPLE_W-1:0] loud_value();
    int unsigned                  m;
    logic [qrr_pkg::SAMPLE_W-1:0] v;
    m = $urandom_range(int'(quiet_limit) + 1, 32768);
    if (m == 32768) return 16'h8000;
    v = 16'(m);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  task automatic send_quiet_run(input int unsigned n);
    repeat (n) send_sample(quiet_value(), 1'b0);
  endtask

  // field extremes at the lowest and highest noise level
  task automatic test_extremes();
    set_noise_level(32'd0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'h0000, 1'b1);
    send_sample(16'hFFFF, 1'b1);
    set_noise_level(32'd32767);
    // -32768 has magnitude 32768, so stays loud
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8001, 1'b0);
    send_sample(16'h0000, 1'b1);
  endtask

  // short quiet runs ended by a loud sample, threshold on both signs
  task automatic test_short_runs();
    set_noise_level(32'd100);
    send_sample(16'sd5, 1'b0);
    send_sample(-16'sd100, 1'b0);
    send_sample(16'sd100, 1'b0);
    send_sample(16'sd101, 1'b0);
    send_sample(-16'sd101, 1'b0);
    send_sample(-16'sd7, 1'b0);
    send_sample(16'sd3000, 1'b1);
  endtask

  // clip end on a lone quiet sample, after a short run, and on a loud one
  task automatic test_clip_ends();
    set_noise_level(32'd100);
    send_sample(16'sd64, 1'b1);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd2, 1'b0);
    send_sample(16'sd3, 1'b0);
    send_sample(-16'sd4, 1'b1);
    send_sample(16'sd200, 1'b1);
  endtask

  // runs around MIN_RUN: kept whole, dropped, saturated count
  task automatic test_long_runs();
    set_noise_level(32'd1000);
    send_quiet_run(MIN_RUN - 2);
    send_sample(loud_value(), 1'b0);
    send_quiet_run(MIN_RUN - 1);
    send_sample(loud_value(), 1'b0);
    send_quiet_run(MIN_RUN + 1);
    send_sample(loud_value(), 1'b0);
    // clip end inside a run: the final sample ends the run and does not count towards it
    send_quiet_run(MIN_RUN - 2);
    send_sample(quiet_value(), 1'b1);
    send_quiet_run(MIN_RUN - 1);
    send_sample(quiet_value(), 1'b1);
  endtask

  // upper data bits are dropped, a write past the register list changes nothing
  task automatic test_spare_register();
    set_noise_level(32'hFFFF_8032);
    write_register(SPARE_REG_ADDR, 32'hFFFF_FFFF);
    send_sample(16'sd1000, 1'b0);
    send_sample(16'sd20, 1'b0);
    send_sample(-16'sd50, 1'b0);
    send_sample(16'sd51, 1'b1);
  endtask

  // mostly short runs with random content, now and then one around MIN_RUN
  task automatic random_runs(input int unsigned n_items);
    int unsigned sent;
    int unsigned run;
    int unsigned pick;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 9);
      if (pick < 9) run = $urandom_range(0, 6);
      else run = $urandom_range(MIN_RUN - 3, MIN_RUN + 1);
      repeat (run) begin
        if ($urandom_range(0, 19) == 0) begin
          send_sample(16'($urandom), $urandom_range(0, 7) == 0);
        end else begin
          send_sample(quiet_value(), 1'b0);
        end
        sent++;
      end
      case ($urandom_range(0, 2))
        0: begin
          send_sample(loud_value(), 1'b0);
        end
        1: begin
          send_sample(loud_value(), 1'b1);
        end
        default: begin
          send_sample(quiet_value(), 1'b1);
        end
      endcase
      sent++;
    end
    // close the clip so the next level starts a fresh run
    send_sample(quiet_value(), 1'b1);
  endtask

  task automatic test_random();
    set_noise_level(32'd0);
    random_runs(6);
    set_noise_level(32'd32767);
    random_runs(6);
    set_noise_level(32'($urandom_range(1, 32766)));
    random_runs(6);
    set_noise_level(32'($urandom_range(1, 300)));
    random_runs(6);
    // last stretch runs with no idling on either side
    set_noise_level(32'($urandom_range(0, 2000)));
    idling_on = 1'b0;
    random_runs(6);
  endtask

  // receiver: random stall bursts while idling is on
  initial begin : sink_stall
    int unsigned hold;
    hold          = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold == 0 && idling_on && $urandom_range(0, 5) == 0) hold = $urandom_range(1, 16);
      if (hold != 0) begin
        m_axis_tready = 1'b0;
        hold--;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // compare each accepted result with the oldest expected one
  always @(posedge clk_i) begin : kept_check
    qrr_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (kept_fifo.size() == 0) begin
        $display("%0t: unexpected item: sample %h last %b done %b", $time,
                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
        mismatch_count++;
      end else begin
        want = kept_fifo.pop_front();
        if (want.sample !== m_axis_tdata || want.run_last !== m_axis_tlast ||
            want.clip_done !== m_axis_tuser) begin
          $display("%0t: mismatch: expected sample %h last %b done %b, got %h %b %b", $time,
                   want.sample, want.run_last, want.clip_done,
                   m_axis_tdata, m_axis_tlast, m_axis_tuser);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_extremes();
    test_short_runs();
    test_clip_ends();
    test_long_runs();
    test_spare_register();
    test_random();
    wait_idle();
    if (mismatch_count == 0 && kept_fifo.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb_top failed");
    $finish;
  end

endmodule
